// ----- sv/ppla_pkg.sv -----
// Shared types and constants for the pointer path length accumulator.
`default_nettype none

package ppla_pkg;

  localparam int TOTAL_BITS   = 48;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_SCALE_X = 2'd1,
    CFG_SCALE_Y = 2'd2
  } cfg_reg_t;

  localparam logic OP_MOVE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

endpackage

`default_nettype wire

// ----- sv/ppla_in_if.sv -----
// Input channel carrying pointer samples and clear commands.
`default_nettype none

interface ppla_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, operation, pos_x, pos_y, input ready);
  modport sink (input valid, operation, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

// ----- sv/ppla_out_if.sv -----
// Result channel carrying the path total and its status flags.
`default_nettype none

interface ppla_out_if;
  logic                            valid;
  logic                            ready;
  logic [ppla_pkg::TOTAL_BITS-1:0] total_mm;
  logic                            added;
  logic                            saturated;

  modport source (output valid, total_mm, added, saturated, input ready);
  modport sink (input valid, total_mm, added, saturated, output ready);
endinterface

`default_nettype wire

// ----- sv/pointer_path_length_accumulator.sv -----
// Top level of the pointer path length accumulator with its multiply and square root sequencer.
// A move with a previous point runs, after acceptance, through the multiplier steps, the square
// root steps, the total update and the result load; a clear, a disabled or a first move goes
// straight to the result load. A new transaction is accepted only in the idle state, after
// the previous result has been loaded; loading stalls while the earlier result waits to be taken.
// Synchronous active-low reset clears the total and the last point and restores the registers.
`default_nettype none

module pointer_path_length_accumulator #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  ppla_in_if.sink                                   in_ch,
  ppla_out_if.source                                out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [ppla_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [FRAC_BITS+1:0]                 cfg_data
);
  import ppla_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int SW   = FRAC_BITS + 2;
  localparam int MW   = CW + SW;
  localparam int HW   = (MW + 1) / 2;
  localparam int AW   = (CW > HW) ? CW : HW;
  localparam int BW   = (SW > HW) ? SW : HW;
  localparam int PW   = AW + BW;
  localparam int RW   = MW + 1;
  localparam int RADW = 2 * RW;
  localparam int CNTW = $clog2(RW);
  localparam int SUMW = ((RW > TOTAL_BITS) ? RW : TOTAL_BITS) + 1;

  localparam logic [63:0]   SCALE_RST_W = ((64'd254 << FRAC_BITS) + 64'd480) / 64'd960;
  localparam logic [SW-1:0] SCALE_RST   = SCALE_RST_W[SW-1:0];
  localparam logic [3:0]    MUL_LAST    = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SQRT,
    S_ADD,
    S_OUT
  } state_t;

  state_t                 state_r;
  logic                   enable_r;
  logic [SW-1:0]          scale_x_r;
  logic [SW-1:0]          scale_y_r;
  logic [CW-1:0]          last_x_r;
  logic [CW-1:0]          last_y_r;
  logic                   have_last_r;
  logic [TOTAL_BITS-1:0]  total_r;
  logic                   added_r;
  logic [CW-1:0]          dx_r;
  logic [CW-1:0]          dy_r;
  logic [MW-1:0]          mx_r;
  logic [MW-1:0]          my_r;
  logic [PW-1:0]          prod_r;
  logic [3:0]             step_r;
  logic [RADW-1:0]        rad_r;
  logic [RW+1:0]          rem_r;
  logic [RW-1:0]          root_r;
  logic [CNTW-1:0]        cnt_r;
  logic                   out_valid_r;
  logic [TOTAL_BITS-1:0]  out_total_r;
  logic                   out_added_r;
  logic                   out_sat_r;

  logic signed [CW:0]     dxs;
  logic signed [CW:0]     dys;
  logic signed [CW:0]     dxn;
  logic signed [CW:0]     dyn;
  logic [CW-1:0]          dx_abs;
  logic [CW-1:0]          dy_abs;
  logic [AW-1:0]          mul_a;
  logic [BW-1:0]          mul_b;
  logic [RADW-1:0]        acc_term;
  logic [RW+1:0]          rem_sh;
  logic [RW+1:0]          trial;
  logic [RW+1:0]          rem_nxt;
  logic [RW-1:0]          root_nxt;
  logic [SUMW-1:0]        sum;
  logic [TOTAL_BITS-1:0]  total_nxt;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.total_mm  = out_total_r;
  assign out_ch.added     = out_added_r;
  assign out_ch.saturated = out_sat_r;

  assign dxs    = {in_ch.pos_x[CW-1], in_ch.pos_x} - {last_x_r[CW-1], last_x_r};
  assign dys    = {in_ch.pos_y[CW-1], in_ch.pos_y} - {last_y_r[CW-1], last_y_r};
  assign dxn    = -dxs;
  assign dyn    = -dys;
  assign dx_abs = dxs[CW] ? dxn[CW-1:0] : dxs[CW-1:0];
  assign dy_abs = dys[CW] ? dyn[CW-1:0] : dys[CW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r) inside
      4'd0: begin
        mul_a = AW'(dx_r);
        mul_b = BW'(scale_x_r);
      end
      4'd1: begin
        mul_a = AW'(dy_r);
        mul_b = BW'(scale_y_r);
      end
      4'd2: begin
        mul_a = AW'(mx_r[HW-1:0]);
        mul_b = BW'(mx_r[HW-1:0]);
      end
      4'd3: begin
        mul_a = AW'(mx_r[MW-1:HW]);
        mul_b = BW'(mx_r[HW-1:0]);
      end
      4'd4: begin
        mul_a = AW'(mx_r[MW-1:HW]);
        mul_b = BW'(mx_r[MW-1:HW]);
      end
      4'd5: begin
        mul_a = AW'(my_r[HW-1:0]);
        mul_b = BW'(my_r[HW-1:0]);
      end
      4'd6: begin
        mul_a = AW'(my_r[MW-1:HW]);
        mul_b = BW'(my_r[HW-1:0]);
      end
      4'd7: begin
        mul_a = AW'(my_r[MW-1:HW]);
        mul_b = BW'(my_r[MW-1:HW]);
      end
      default: begin
      end
    endcase
  end

  // The product of step n is consumed in step n+1; the cross term is doubled by its shift.
  always_comb begin
    case (step_r) inside
      4'd3, 4'd6: acc_term = RADW'(prod_r);
      4'd4, 4'd7: acc_term = RADW'(prod_r) << (HW + 1);
      4'd5, 4'd8: acc_term = RADW'(prod_r) << (2 * HW);
      default:    acc_term = '0;
    endcase
  end

  assign rem_sh = {rem_r[RW-1:0], rad_r[RADW-1:RADW-2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[RW-2:0], 1'b0};
    end
  end

  assign sum       = SUMW'(total_r) + SUMW'(root_r);
  assign total_nxt = (sum >= SUMW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b1;
      scale_x_r <= SCALE_RST;
      scale_y_r <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:  enable_r  <= cfg_data[0];
        CFG_SCALE_X: scale_x_r <= cfg_data;
        CFG_SCALE_Y: scale_y_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_x_r    <= '0;
      last_y_r    <= '0;
      have_last_r <= 1'b0;
      total_r     <= '0;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      added_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            added_r <= 1'b0;
            state_r <= S_OUT;
            if (in_ch.operation == OP_CLEAR) begin
              total_r     <= '0;
              have_last_r <= 1'b0;
            end else if (enable_r) begin
              last_x_r    <= in_ch.pos_x;
              last_y_r    <= in_ch.pos_y;
              have_last_r <= 1'b1;
              if (have_last_r) begin
                dx_r    <= dx_abs;
                dy_r    <= dy_abs;
                step_r  <= '0;
                rad_r   <= '0;
                state_r <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          prod_r <= PW'(mul_a * mul_b);
          if (step_r == 4'd1) begin
            mx_r <= prod_r[MW-1:0];
          end
          if (step_r == 4'd2) begin
            my_r <= prod_r[MW-1:0];
          end
          rad_r  <= rad_r + acc_term;
          step_r <= step_r + 4'd1;
          if (step_r == MUL_LAST) begin
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CNTW'(RW - 1);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          rad_r  <= {rad_r[RADW-3:0], 2'b00};
          cnt_r  <= cnt_r - CNTW'(1);
          if (cnt_r == '0) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (root_r != '0) begin
            added_r <= 1'b1;
            total_r <= total_nxt;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_total_r <= total_r;
            out_added_r <= added_r;
            out_sat_r   <= (total_r == TOTAL_MAX);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
